/* rtl/core/gnpo_pkg.sv */
// Package for the greedy nearest-point orderer.
// Holds sizes, codes, payload structs and the control structs shared by the core modules.
// No dependencies.
package gnpo_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned SQ_W       = 2 * COORD_BITS;
  localparam int unsigned DIST_W     = SQ_W + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_TAKE   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RETURNED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    action_e action;
    coord_t  point_x;
    coord_t  point_y;
  } cmd_t;

  typedef struct packed {
    status_e status;
    coord_t  out_x;
    coord_t  out_y;
    count_t  remaining;
    logic    run_done;
  } result_t;

  // One slot of the point memory; taken marks a point already handed out.
  typedef struct packed {
    logic   taken;
    coord_t x;
    coord_t y;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic  clear;     // start of a new scan
    logic  rd_valid;  // memory read data belongs to the scan
    slot_t rd_idx;    // slot of that read data
    logic  nearest;   // 1: nearest to current point, 0: newest slot
  } scan_ctl_t;

  typedef struct packed {
    logic   found;
    slot_t  idx;
    coord_t x;
    coord_t y;
  } best_t;

endpackage

/* rtl/core/gnpo_store.sv */
// Point memory: one write port, one read port, registered read data.
// Depends on gnpo_pkg.
module gnpo_store (
  input  logic             clk_i,
  input  logic             we_i,
  input  gnpo_pkg::slot_t  waddr_i,
  input  gnpo_pkg::entry_t wdata_i,
  input  gnpo_pkg::slot_t  raddr_i,
  output gnpo_pkg::entry_t rdata_o
);
  import gnpo_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gnpo_dist.sv */
// Scan datapath: squared distance pipeline and running best-candidate tracker.
// Depends on gnpo_pkg.
module gnpo_dist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gnpo_pkg::scan_ctl_t ctl_i,
  input  gnpo_pkg::entry_t    entry_i,
  input  gnpo_pkg::coord_t    cur_x_i,
  input  gnpo_pkg::coord_t    cur_y_i,
  output logic                pipe_busy_o,
  output gnpo_pkg::best_t     best_o
);
  import gnpo_pkg::*;

  coord_t            dx, dy;
  logic [SQ_W-1:0]   sqx_d, sqy_d;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic              v2_q;
  slot_t             idx2_q;
  coord_t            x2_q, y2_q;
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_d_q;
  logic              found_q;
  slot_t             best_idx_q;
  coord_t            best_x_q, best_y_q;
  logic              update;

  // stage 1: absolute differences and squares
  always_comb begin
    dx    = (entry_i.x > cur_x_i) ? entry_i.x - cur_x_i : cur_x_i - entry_i.x;
    dy    = (entry_i.y > cur_y_i) ? entry_i.y - cur_y_i : cur_y_i - entry_i.y;
    sqx_d = SQ_W'(dx) * SQ_W'(dx);
    sqy_d = SQ_W'(dy) * SQ_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= ctl_i.rd_valid && !entry_i.taken;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    idx2_q <= ctl_i.rd_idx;
    x2_q   <= entry_i.x;
    y2_q   <= entry_i.y;
  end

  // stage 2: sum and compare; strict less keeps the lowest slot on ties,
  // newest mode lets the last live slot win
  always_comb begin
    dist_sum = DIST_W'(sqx_q) + DIST_W'(sqy_q);
    update   = v2_q && (!ctl_i.nearest || !found_q || (dist_sum < best_d_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (update) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      best_d_q   <= dist_sum;
      best_idx_q <= idx2_q;
      best_x_q   <= x2_q;
      best_y_q   <= y2_q;
    end
  end

  assign pipe_busy_o  = v2_q;
  assign best_o.found = found_q;
  assign best_o.idx   = best_idx_q;
  assign best_o.x     = best_x_q;
  assign best_o.y     = best_y_q;

endmodule

/* rtl/core/greedy_nearest_point_orderer_unit.sv */
// Channel   Ports                              Transfer
// command   start, busy, cmd_i                 start && !busy at clk_i rise
// result    result_valid_o, result_o           one-cycle strobe, no back-pressure
//
// Insert and take-on-empty: busy stays low, result strobes the cycle after the transaction.
// Take: busy through the scan, the drain and the write-back; the
// scan reads one memory slot per cycle over all slots filled since the set was last empty,
// then a drain until the read and distance pipeline is empty, and a write-back; result
// strobes in the same cycle that busy falls.
// rst_ni clears control state; the point memory needs no clearing, live slots are
// those below write_slot whose taken flag is clear.
// Depends on gnpo_pkg, gnpo_store, gnpo_dist.
module greedy_nearest_point_orderer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gnpo_pkg::cmd_t    cmd_i,
  output logic              result_valid_o,
  output gnpo_pkg::result_t result_o
);
  import gnpo_pkg::*;

  state_e    state_q, state_d;
  count_t    write_slot_q;
  count_t    remain_q;
  coord_t    cur_x_q, cur_y_q;
  logic      run_active_q;
  slot_t     rd_addr_q;
  logic      rd_v_q;
  slot_t     rd_idx_q;
  result_t   res_d, res_q;
  logic      res_valid_q;

  logic      accept, is_take, full, set_empty, scan_last;
  logic      scan_start, scan_issue, finish, ins_ok;
  logic      pipe_busy;
  logic      mem_we;
  slot_t     mem_waddr;
  entry_t    mem_wdata, mem_rdata;
  scan_ctl_t scan_ctl;
  best_t     best;

  assign accept    = start && !busy;
  assign is_take   = (cmd_i.action == ACT_TAKE);
  assign full      = (write_slot_q == count_t'(CAPACITY));
  assign set_empty = (remain_q == '0);
  assign scan_last = (count_t'(rd_addr_q) == (write_slot_q - count_t'(1)));
  assign ins_ok    = accept && !is_take && !full;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept && is_take && !set_empty) state_d = S_SCAN;
      S_SCAN:   if (scan_last) state_d = S_DRAIN;
      S_DRAIN:  if (!rd_v_q && !pipe_busy) state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy       = (state_q != S_IDLE);
    scan_start = (state_q == S_IDLE) && accept && is_take && !set_empty;
    scan_issue = (state_q == S_SCAN);
    finish     = (state_q == S_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // read address and alignment with the memory's read latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_v_q    <= 1'b0;
    end else begin
      rd_v_q <= scan_issue;
      if (scan_start) begin
        rd_addr_q <= '0;
      end else if (scan_issue) begin
        rd_addr_q <= rd_addr_q + slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr_q;
  end

  // at most one write per transaction: new point on insert, taken flag on take
  always_comb begin
    mem_we = ins_ok || finish;
    if (finish) begin
      mem_waddr       = best.idx;
      mem_wdata.taken = 1'b1;
      mem_wdata.x     = best.x;
      mem_wdata.y     = best.y;
    end else begin
      mem_waddr       = write_slot_q[SLOT_W-1:0];
      mem_wdata.taken = 1'b0;
      mem_wdata.x     = cmd_i.point_x;
      mem_wdata.y     = cmd_i.point_y;
    end
  end

  gnpo_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  assign scan_ctl.clear    = scan_start;
  assign scan_ctl.rd_valid = rd_v_q;
  assign scan_ctl.rd_idx   = rd_idx_q;
  assign scan_ctl.nearest  = run_active_q;

  gnpo_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .entry_i     (mem_rdata),
    .cur_x_i     (cur_x_q),
    .cur_y_i     (cur_y_q),
    .pipe_busy_o (pipe_busy),
    .best_o      (best)
  );

  // set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      remain_q     <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      run_active_q <= 1'b0;
    end else if (finish) begin
      cur_x_q  <= best.x;
      cur_y_q  <= best.y;
      remain_q <= remain_q - count_t'(1);
      if (remain_q == count_t'(1)) begin
        write_slot_q <= '0;
        run_active_q <= 1'b0;
      end else begin
        run_active_q <= 1'b1;
      end
    end else if (ins_ok) begin
      write_slot_q <= write_slot_q + count_t'(1);
      remain_q     <= remain_q + count_t'(1);
    end
  end

  // result
  always_comb begin
    res_d = '0;
    priority if (finish) begin
      res_d.status    = ST_RETURNED;
      res_d.out_x     = best.x;
      res_d.out_y     = best.y;
      res_d.remaining = remain_q - count_t'(1);
      res_d.run_done  = (remain_q == count_t'(1));
    end else if (is_take) begin
      res_d.status    = ST_EMPTY;
      res_d.remaining = remain_q;
    end else if (full) begin
      res_d.status    = ST_FULL;
      res_d.remaining = remain_q;
    end else begin
      res_d.status    = ST_INSERTED;
      res_d.remaining = remain_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= finish || (accept && !scan_start);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // a finished scan always has a live candidate
  a_finish_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |-> best.found)
    else $error("take finished without a candidate");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= write_slot_q)
    else $error("remaining count exceeds filled slots");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && cmd_i.action == ACT_TAKE))
    else $error("busy raised without a take transaction");

  a_returned_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_RETURNED) |-> $past(state_q == S_FINISH))
    else $error("point returned outside a finished scan");

endmodule
